// File: hdl/ietp_pkg.sv
// Shared types and constants for the interrupt table entry parser.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package ietp_pkg;

  // Sizing
  localparam int MAX_LAPICS_DEF = 256;
  localparam int QUEUE_DEPTH    = 8;
  localparam int CFG_ADDR_W     = 4;

  // Register indexes (word address bits [3:2] of the configuration port)
  localparam logic [1:0] REG_LOCAL_TYPE   = 2'd0;
  localparam logic [1:0] REG_IO_TYPE      = 2'd1;
  localparam logic [1:0] REG_ENABLED_MASK = 2'd2;

  localparam logic [7:0]  LOCAL_TYPE_RST   = 8'd0;
  localparam logic [7:0]  IO_TYPE_RST      = 8'd1;
  localparam logic [31:0] ENABLED_MASK_RST = 32'd1;

  // Record kinds
  localparam logic KIND_LOCAL_ID = 1'b0;
  localparam logic KIND_SUMMARY  = 1'b1;

  // Table layout
  localparam logic [31:0] DEFAULT_LOCAL_BASE = 32'hFEE0_0000;
  localparam logic [5:0]  HDR_BASE_FIRST     = 6'd36;
  localparam logic [5:0]  HDR_BASE_LAST      = 6'd39;
  localparam logic [5:0]  ENTRY_START        = 6'd44;
  localparam logic [7:0]  MIN_ENTRY_LEN      = 8'd2;
  localparam logic [7:0]  LAST_SCRATCH_POS   = 8'd11;

  typedef struct packed {
    logic [7:0]  local_type;
    logic [7:0]  io_type;
    logic [31:0] enabled_mask;
  } cfg_t;

  typedef struct packed {
    logic push_id;
    logic push_sum;
  } push_t;

  typedef struct packed {
    logic        record_kind;
    logic [7:0]  local_id;
    logic        sum_ok;
    logic [8:0]  local_count;
    logic [31:0] local_base;
    logic        io_found;
    logic [31:0] io_base;
    logic [31:0] io_irq_base;
    logic [7:0]  io_id;
    logic        malformed;
    logic        run_end;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/ietp_parser.sv
// Table walker: byte sum, header base capture, entry walk and record generation.
// Depends on ietp_pkg for the configuration, push and result types.
`default_nettype none

module ietp_parser #(
  parameter int MAX_LAPICS = ietp_pkg::MAX_LAPICS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_valid,
  input  wire logic [7:0]       item_byte,
  input  wire logic             item_last,
  input  wire ietp_pkg::cfg_t   cfg,
  output ietp_pkg::push_t       push,
  output ietp_pkg::result_t     id_rec,
  output ietp_pkg::result_t     sum_rec
);

  localparam logic [8:0] MAX_CNT = 9'(MAX_LAPICS);

  logic [5:0]  off_r,   off_nxt;
  logic [7:0]  sum_r,   sum_nxt;
  logic [31:0] hdr_r,   hdr_nxt;
  logic [7:0]  pos_r,   pos_nxt;
  logic [7:0]  type_r,  type_nxt;
  logic [7:0]  len_r,   len_nxt;
  logic [79:0] scr_r,   scr_nxt;
  logic [8:0]  cnt_r,   cnt_nxt;
  logic [7:0]  io_id_r, io_id_nxt;
  logic [31:0] io_base_r, io_base_nxt;
  logic [31:0] io_irq_r,  io_irq_nxt;
  logic        stop_r,  stop_nxt;

  logic [3:0]  pos_m2;
  logic        walk;
  logic        done;
  logic        fin;
  logic        emit;

  // Scratch slot of the current entry byte; only used for positions 2 to 11.
  assign pos_m2 = pos_r[3:0] - 4'd2;

  always_comb begin
    off_nxt     = (off_r == ietp_pkg::ENTRY_START) ? off_r : off_r + 6'd1;
    sum_nxt     = sum_r + item_byte;
    hdr_nxt     = hdr_r;
    pos_nxt     = pos_r;
    type_nxt    = type_r;
    len_nxt     = len_r;
    scr_nxt     = scr_r;
    cnt_nxt     = cnt_r;
    io_id_nxt   = io_id_r;
    io_base_nxt = io_base_r;
    io_irq_nxt  = io_irq_r;
    stop_nxt    = stop_r;
    done        = 1'b0;
    fin         = 1'b0;
    emit        = 1'b0;

    // Header bytes 36..39 hold the local controller base, little-endian.
    if (off_r >= ietp_pkg::HDR_BASE_FIRST && off_r <= ietp_pkg::HDR_BASE_LAST) begin
      hdr_nxt[{off_r[1:0], 3'b000} +: 8] = item_byte;
    end

    walk = (off_r >= ietp_pkg::ENTRY_START) && !stop_r;
    if (walk) begin
      if (pos_r == 8'd0) begin
        type_nxt = item_byte;
        scr_nxt  = '0;
      end else if (pos_r == 8'd1) begin
        len_nxt = item_byte;
        if (item_byte < ietp_pkg::MIN_ENTRY_LEN) begin
          stop_nxt = 1'b1;
        end else begin
          done = (item_byte == ietp_pkg::MIN_ENTRY_LEN);
        end
      end else begin
        if (pos_r <= ietp_pkg::LAST_SCRATCH_POS) begin
          scr_nxt[{pos_m2, 3'b000} +: 8] = item_byte;
        end
        done = (({1'b0, pos_r} + 9'd1) == {1'b0, len_r});
      end
      if (!stop_nxt) begin
        if (done) begin
          pos_nxt = 8'd0;
          fin     = 1'b1;
        end else begin
          pos_nxt = pos_r + 8'd1;
        end
      end
    end

    // Entry complete: a local entry type takes precedence over the I/O type.
    if (fin) begin
      if (type_r == cfg.local_type) begin
        if (((scr_nxt[47:16] & cfg.enabled_mask) != 32'd0) && (cnt_r < MAX_CNT)) begin
          emit    = 1'b1;
          cnt_nxt = cnt_r + 9'd1;
        end
      end else if (type_r == cfg.io_type) begin
        if (io_base_r == 32'd0) begin
          io_id_nxt   = scr_nxt[7:0];
          io_base_nxt = scr_nxt[47:16];
          io_irq_nxt  = scr_nxt[79:48];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (item_valid && item_last)) begin
      off_r     <= '0;
      sum_r     <= '0;
      hdr_r     <= '0;
      pos_r     <= '0;
      type_r    <= '0;
      len_r     <= '0;
      scr_r     <= '0;
      cnt_r     <= '0;
      io_id_r   <= '0;
      io_base_r <= '0;
      io_irq_r  <= '0;
      stop_r    <= 1'b0;
    end else if (item_valid) begin
      off_r     <= off_nxt;
      sum_r     <= sum_nxt;
      hdr_r     <= hdr_nxt;
      pos_r     <= pos_nxt;
      type_r    <= type_nxt;
      len_r     <= len_nxt;
      scr_r     <= scr_nxt;
      cnt_r     <= cnt_nxt;
      io_id_r   <= io_id_nxt;
      io_base_r <= io_base_nxt;
      io_irq_r  <= io_irq_nxt;
      stop_r    <= stop_nxt;
    end
  end

  assign push.push_id  = item_valid && emit;
  assign push.push_sum = item_valid && item_last;

  always_comb begin
    id_rec             = '0;
    id_rec.record_kind = ietp_pkg::KIND_LOCAL_ID;
    id_rec.local_id    = scr_nxt[15:8];
    id_rec.run_end     = !item_last;

    sum_rec             = '0;
    sum_rec.record_kind = ietp_pkg::KIND_SUMMARY;
    sum_rec.sum_ok      = (sum_nxt == 8'd0);
    sum_rec.local_count = cnt_nxt;
    sum_rec.local_base  = (hdr_nxt != 32'd0) ? hdr_nxt : ietp_pkg::DEFAULT_LOCAL_BASE;
    sum_rec.io_found    = (io_base_nxt != 32'd0);
    sum_rec.io_base     = io_base_nxt;
    sum_rec.io_irq_base = io_irq_nxt;
    sum_rec.io_id       = io_id_nxt;
    sum_rec.malformed   = stop_nxt;
    sum_rec.run_end     = 1'b1;
  end

endmodule

`default_nettype wire

// File: hdl/ietp_outq.sv
// Result queue: takes up to two records per cycle (id first, then summary), hands out one.
// Depends on ietp_pkg for the push and result types.
`default_nettype none

module ietp_outq #(
  parameter  int DEPTH = ietp_pkg::QUEUE_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ietp_pkg::push_t   push,
  input  wire ietp_pkg::result_t id_rec,
  input  wire ietp_pkg::result_t sum_rec,
  input  wire logic              pop,
  output ietp_pkg::result_t      head,
  output logic [CNT_W-1:0]       count
);

  localparam int PTR_W = $clog2(DEPTH);

  ietp_pkg::result_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt, wr1;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr1 = wrap_inc(wr_r);
    if (push.push_id && push.push_sum) begin
      wr_nxt = wrap_inc(wr1);
    end else if (push.push_id || push.push_sum) begin
      wr_nxt = wr1;
    end else begin
      wr_nxt = wr_r;
    end
    rd_nxt  = pop ? wrap_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + CNT_W'(push.push_id) + CNT_W'(push.push_sum) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Record storage needs no reset; the count guards every read.
  always_ff @(posedge clk) begin
    if (push.push_id) begin
      mem_r[wr_r] <= id_rec;
    end
    if (push.push_sum) begin
      mem_r[push.push_id ? wr1 : wr_r] <= sum_rec;
    end
  end

  assign head  = mem_r[rd_r];
  assign count = cnt_r;

endmodule

`default_nettype wire

// File: hdl/interrupt_table_entry_parser_unit.sv
// Top level of the interrupt table entry parser: configuration registers, input stage,
// parser and result queue. Depends on ietp_pkg, ietp_parser and ietp_outq.
//
// Usage. The table is streamed in one byte per request on the in_ channel (valid/ready),
// from table offset zero, with in_last_byte set on the final byte. Each complete,
// enabled local controller entry, up to MAX_LAPICS per table, yields one record
// of kind 0 carrying its id; the final byte yields a summary record of kind 1
// (checksum status, count, bases, first I/O controller, malformed flag). A final
// byte that also completes an enabled local entry yields both records, id first,
// and only the summary carries run_end. A byte accepted at one clock edge is held in
// the input stage and its records enter the result queue at the next edge, which
// raises out_valid. Throughput is one byte per cycle while in_ready is high; the parser
// needs only a small field update per byte, done combinationally between input stage
// and queue.
// The eight-entry result queue decouples the two sides: bytes keep flowing while
// records wait for out_ready. in_ready falls only when the queue, counting the two
// records that the byte in the input stage may still add, has fewer than two free slots.
// Reset (rst_n low, synchronous) loads the registers with their reset values and
// clears the parse state and the queue. After each final byte the parse state returns
// to its reset value ready for the next table; the configuration registers keep theirs.
// Registers may only be written while no request is in flight.
`default_nettype none

module interrupt_table_entry_parser_unit #(
  parameter int MAX_LAPICS = ietp_pkg::MAX_LAPICS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Table byte channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_last_byte,
  // Result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_record_kind,
  output logic [7:0]                         out_local_id,
  output logic                               out_sum_ok,
  output logic [8:0]                         out_local_count,
  output logic [31:0]                        out_local_base,
  output logic                               out_io_found,
  output logic [31:0]                        out_io_base,
  output logic [31:0]                        out_io_irq_base,
  output logic [7:0]                         out_io_id,
  output logic                               out_malformed,
  output logic                               out_run_end,
  // Configuration port
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [ietp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int QD    = ietp_pkg::QUEUE_DEPTH;
  localparam int CNT_W = $clog2(QD + 1);

  // Configuration registers
  ietp_pkg::cfg_t cfg_r;
  logic           cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_type   <= ietp_pkg::LOCAL_TYPE_RST;
      cfg_r.io_type      <= ietp_pkg::IO_TYPE_RST;
      cfg_r.enabled_mask <= ietp_pkg::ENABLED_MASK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        ietp_pkg::REG_LOCAL_TYPE:   cfg_r.local_type   <= cfg_pwdata[7:0];
        ietp_pkg::REG_IO_TYPE:      cfg_r.io_type      <= cfg_pwdata[7:0];
        ietp_pkg::REG_ENABLED_MASK: cfg_r.enabled_mask <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      ietp_pkg::REG_LOCAL_TYPE:   cfg_prdata = {24'd0, cfg_r.local_type};
      ietp_pkg::REG_IO_TYPE:      cfg_prdata = {24'd0, cfg_r.io_type};
      ietp_pkg::REG_ENABLED_MASK: cfg_prdata = cfg_r.enabled_mask;
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  // Input stage. A byte is only taken when the queue can absorb the records of both the
  // byte already in the stage and the new one, so the stage never has to wait.
  logic             stg_v_r;
  logic [7:0]       stg_byte_r;
  logic             stg_last_r;
  logic [CNT_W-1:0] q_count;
  logic [CNT_W:0]   q_need;
  logic             in_acc;

  assign q_need   = (CNT_W + 1)'(q_count) + (stg_v_r ? (CNT_W + 1)'(2) : '0)
                  + (CNT_W + 1)'(2);
  assign in_ready = (q_need <= (CNT_W + 1)'(QD));
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_data_byte;
      stg_last_r <= in_last_byte;
    end
  end

  // Parser and result queue
  ietp_pkg::push_t   push;
  ietp_pkg::result_t id_rec;
  ietp_pkg::result_t sum_rec;
  ietp_pkg::result_t head;
  logic              pop;

  ietp_parser #(
    .MAX_LAPICS (MAX_LAPICS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (stg_v_r),
    .item_byte  (stg_byte_r),
    .item_last  (stg_last_r),
    .cfg        (cfg_r),
    .push       (push),
    .id_rec     (id_rec),
    .sum_rec    (sum_rec)
  );

  ietp_outq #(
    .DEPTH (QD)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .id_rec  (id_rec),
    .sum_rec (sum_rec),
    .pop     (pop),
    .head    (head),
    .count   (q_count)
  );

  assign out_valid = (q_count != '0);
  assign pop       = out_valid && out_ready;

  assign out_record_kind = head.record_kind;
  assign out_local_id    = head.local_id;
  assign out_sum_ok      = head.sum_ok;
  assign out_local_count = head.local_count;
  assign out_local_base  = head.local_base;
  assign out_io_found    = head.io_found;
  assign out_io_base     = head.io_base;
  assign out_io_irq_base = head.io_irq_base;
  assign out_io_id       = head.io_id;
  assign out_malformed   = head.malformed;
  assign out_run_end     = head.run_end;

  // A byte in the input stage always finds room for both of its possible records.
  a_stage_room: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r |-> ((CNT_W + 1)'(q_count) + (CNT_W + 1)'(2) <= (CNT_W + 1)'(QD)))
    else $error("input stage holds a byte without queue room for its records");

  // The summary is always the last record of its byte.
  a_summary_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_kind == ietp_pkg::KIND_SUMMARY) |-> out_run_end)
    else $error("summary record without run_end");

  // Id records carry no summary content.
  a_id_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_kind == ietp_pkg::KIND_LOCAL_ID) |->
      (out_local_count == 9'd0 && out_local_base == 32'd0 && !out_io_found
       && !out_sum_ok && !out_malformed))
    else $error("id record carries summary fields");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for interrupt_table_entry_parser_unit: streams whole tables byte by byte,
// predicts every id and summary record and checks them in order. Needs only ietp_pkg and the RTL.

module tb_top;

  // Drain wait after the last predicted record, covering a late record.
  localparam int DRAIN_CYCLES = 6;
  // Longest quiet stretch of a correct run is the deliberate result hold-off below.
  localparam int RESULT_HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BYTES_PER_PHASE = 60;

  typedef enum {SUM_KEEP, SUM_FIX, SUM_BREAK} checksum_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            in_data_byte = 8'd0;
  logic                  in_last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_record_kind;
  logic [7:0]            out_local_id;
  logic                  out_sum_ok;
  logic [8:0]            out_local_count;
  logic [31:0]           out_local_base;
  logic                  out_io_found;
  logic [31:0]           out_io_base;
  logic [31:0]           out_io_irq_base;
  logic [7:0]            out_io_id;
  logic                  out_malformed;
  logic                  out_run_end;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [ietp_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = 32'd0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  interrupt_table_entry_parser_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_record_kind(out_record_kind),
    .out_local_id   (out_local_id),
    .out_sum_ok     (out_sum_ok),
    .out_local_count(out_local_count),
    .out_local_base (out_local_base),
    .out_io_found   (out_io_found),
    .out_io_base    (out_io_base),
    .out_io_irq_base(out_io_irq_base),
    .out_io_id      (out_io_id),
    .out_malformed  (out_malformed),
    .out_run_end    (out_run_end),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers, updated as each write completes.
  logic [7:0]  cfg_local_type = ietp_pkg::LOCAL_TYPE_RST;
  logic [7:0]  cfg_io_type    = ietp_pkg::IO_TYPE_RST;
  logic [31:0] cfg_mask       = ietp_pkg::ENABLED_MASK_RST;

  // Parse state of the table currently streaming in.
  logic [31:0] tbl_offset;
  logic [7:0]  tbl_sum;
  logic [31:0] hdr_base;
  logic [7:0]  ent_pos;
  logic [7:0]  ent_type;
  logic [7:0]  ent_len;
  logic [7:0]  ent_bytes [10];
  logic [8:0]  enabled_seen;
  logic [7:0]  ioc_id;
  logic [31:0] ioc_base;
  logic [31:0] ioc_irq_base;
  bit          walk_stopped;

  ietp_pkg::result_t pending_records [$];
  logic [7:0]        table_bytes [$];

  int send_idle_pct = 37;
  int recv_idle_pct = 56;
  int error_count = 0;
  int records_checked = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  // Hold-off requests from the test sequence; the receiver owns the countdown.
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 100)
      $display("MISMATCH at record %0d, %s: got 0x%0h, expected 0x%0h",
               records_checked, what, got, want);
    error_count++;
  endtask

  function automatic void clear_parse_state();
    tbl_offset   = 32'd0;
    tbl_sum      = 8'd0;
    hdr_base     = 32'd0;
    ent_pos      = 8'd0;
    ent_type     = 8'd0;
    ent_len      = 8'd0;
    foreach (ent_bytes[k]) ent_bytes[k] = 8'd0;
    enabled_seen = 9'd0;
    ioc_id       = 8'd0;
    ioc_base     = 32'd0;
    ioc_irq_base = 32'd0;
    walk_stopped = 1'b0;
  endfunction

  initial clear_parse_state();

  // Little-endian word from the entry bytes, indexed from entry byte 2.
  function automatic logic [31:0] entry_word(input int at);
    return {ent_bytes[at + 3], ent_bytes[at + 2], ent_bytes[at + 1], ent_bytes[at]};
  endfunction

  // Advances the parse by one accepted byte and queues the records it produces.
  task automatic predict_table_byte(input logic [7:0] b, input logic last);
    ietp_pkg::result_t rec;
    int unsigned       pos;
    bit                done;
    tbl_sum = tbl_sum + b;
    if (tbl_offset >= ietp_pkg::HDR_BASE_FIRST && tbl_offset <= ietp_pkg::HDR_BASE_LAST)
      hdr_base[(tbl_offset - ietp_pkg::HDR_BASE_FIRST) * 8 +: 8] = b;

    if (tbl_offset >= ietp_pkg::ENTRY_START && !walk_stopped) begin
      pos  = ent_pos;
      done = 1'b0;
      if (pos == 0) begin
        ent_type = b;
        foreach (ent_bytes[k]) ent_bytes[k] = 8'd0;
      end else if (pos == 1) begin
        ent_len = b;
        if (b < ietp_pkg::MIN_ENTRY_LEN) walk_stopped = 1'b1;
        else done = (b == ietp_pkg::MIN_ENTRY_LEN);
      end else begin
        if (pos - 2 < 10) ent_bytes[pos - 2] = b;
        done = ((pos + 1) == ent_len);
      end
      if (!walk_stopped) begin
        if (done) begin
          ent_pos = 8'd0;
          // A type matching both codes counts as a local entry.
          if (ent_type == cfg_local_type) begin
            if ((entry_word(2) & cfg_mask) != 32'd0
                && enabled_seen < ietp_pkg::MAX_LAPICS_DEF) begin
              rec             = '0;
              rec.record_kind = ietp_pkg::KIND_LOCAL_ID;
              rec.local_id    = ent_bytes[1];
              rec.run_end     = !last;
              pending_records.push_back(rec);
              enabled_seen++;
            end
          end else if (ent_type == cfg_io_type) begin
            if (ioc_base == 32'd0) begin
              ioc_id       = ent_bytes[0];
              ioc_base     = entry_word(2);
              ioc_irq_base = entry_word(6);
            end
          end
        end else begin
          ent_pos = 8'(pos + 1);
        end
      end
    end

    if (tbl_offset != 32'hFFFF_FFFF) tbl_offset++;

    if (last) begin
      rec             = '0;
      rec.record_kind = ietp_pkg::KIND_SUMMARY;
      rec.sum_ok      = (tbl_sum == 8'd0);
      rec.local_count = enabled_seen;
      rec.local_base  = (hdr_base != 32'd0) ? hdr_base : ietp_pkg::DEFAULT_LOCAL_BASE;
      rec.io_found    = (ioc_base != 32'd0);
      rec.io_base     = ioc_base;
      rec.io_irq_base = ioc_irq_base;
      rec.io_id       = ioc_id;
      rec.malformed   = walk_stopped;
      rec.run_end     = 1'b1;
      pending_records.push_back(rec);
      clear_parse_state();
    end
  endtask

  // One byte request. Entered just after a rising edge; returns just after the
  // edge that accepted the byte, with in_valid still high.
  task automatic send_table_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= value;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_table_byte(value, last);
    bytes_sent++;
  endtask

  // Stops offering bytes and waits until every predicted record has come out,
  // then lets the pipeline settle so that a byte without a record is finished too.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register through the APB port, then reads it back. Returns just
  // after the port has gone idle again.
  task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] width_mask;
    width_mask  = (idx == ietp_pkg::REG_ENABLED_MASK) ? 32'hFFFF_FFFF : 32'h0000_00FF;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      ietp_pkg::REG_LOCAL_TYPE: cfg_local_type = value[7:0];
      ietp_pkg::REG_IO_TYPE:    cfg_io_type = value[7:0];
      default:                  cfg_mask = value;
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if ((cfg_prdata & width_mask) != (value & width_mask))
      report_mismatch("register read-back", cfg_prdata & width_mask, value & width_mask);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_parser_config(input logic [7:0] local_code, input logic [7:0] io_code,
                                   input logic [31:0] mask);
    wait_for_idle();
    program_register(ietp_pkg::REG_LOCAL_TYPE, {24'd0, local_code});
    program_register(ietp_pkg::REG_IO_TYPE, {24'd0, io_code});
    program_register(ietp_pkg::REG_ENABLED_MASK, mask);
  endtask

  // Random 44-byte header carrying the given local controller base.
  task automatic start_table(input logic [31:0] base);
    int k;
    table_bytes.delete();
    for (k = 0; k < ietp_pkg::ENTRY_START; k++) table_bytes.push_back(8'($urandom_range(255)));
    for (k = 0; k < 4; k++) table_bytes[ietp_pkg::HDR_BASE_FIRST + k] = base[8 * k +: 8];
  endtask

  // Appends one entry: bytes 2 and 3, then words at entry bytes 4 and 8,
  // then random filler, cut to the entry length.
  task automatic add_entry(input logic [7:0] code, input logic [7:0] len,
                           input logic [7:0] b2, input logic [7:0] b3,
                           input logic [31:0] w4, input logic [31:0] w8);
    logic [7:0] body [12];
    int         k;
    body[0] = code;
    body[1] = len;
    body[2] = b2;
    body[3] = b3;
    for (k = 0; k < 4; k++) begin
      body[4 + k] = w4[8 * k +: 8];
      body[8 + k] = w8[8 * k +: 8];
    end
    table_bytes.push_back(code);
    table_bytes.push_back(len);
    for (k = 2; k < len; k++)
      table_bytes.push_back((k < 12) ? body[k] : 8'($urandom_range(255)));
  endtask

  task automatic add_local(input logic [7:0] len, input logic [7:0] id, input logic [31:0] flags);
    add_entry(cfg_local_type, len, 8'($urandom_range(255)), id, flags, $urandom);
  endtask

  task automatic add_io(input logic [7:0] len, input logic [7:0] id, input logic [31:0] base,
                        input logic [31:0] irq_base);
    add_entry(cfg_io_type, len, id, 8'd0, base, irq_base);
  endtask

  function automatic logic [31:0] random_flags();
    case ($urandom_range(3))
      0:       return cfg_mask;
      1:       return 32'd0;
      2:       return ~cfg_mask;
      default: return $urandom;
    endcase
  endfunction

  // Fixes or breaks the checksum as the mode asks through header byte 9 (byte 0 for a very
  // short table), or leaves it, then streams the table with the last flag on its final byte.
  task automatic send_table(input checksum_mode_t mode);
    logic [7:0] total;
    int         fix_at;
    int         k;
    total  = 8'd0;
    for (k = 0; k < table_bytes.size(); k++) total = total + table_bytes[k];
    fix_at = (table_bytes.size() > 9) ? 9 : 0;
    if (mode == SUM_FIX) table_bytes[fix_at] = table_bytes[fix_at] - total;
    else if (mode == SUM_BREAK && total == 8'd0)
      table_bytes[fix_at] = table_bytes[fix_at] + 8'd1;
    for (k = 0; k < table_bytes.size(); k++)
      send_table_byte(table_bytes[k], k == table_bytes.size() - 1);
  endtask

  // Reset register values: a zero header base falls back to the default, both
  // id extremes appear and an I/O controller is captured.
  task automatic test_default_registers();
    start_table(32'd0);
    add_local(8'd8, 8'h00, 32'h0000_0001);
    add_io(8'd12, 8'hFF, 32'hFEC0_0000, 32'd0);
    add_local(8'd8, 8'hFF, 32'hFFFF_FFFF);
    add_local(8'd8, 8'h42, 32'hFFFF_FFFE);
    send_table(SUM_FIX);
  endtask

  task automatic test_entry_edge_cases();
    wait_for_idle();
    // Fields past an entry's own length read as zero: flags missing, flags
    // partly present, and an I/O base with its top byte cut away.
    start_table(ietp_pkg::DEFAULT_LOCAL_BASE);
    add_local(8'd4, 8'h11, 32'h0000_0001);
    add_local(8'd5, 8'h12, 32'h0000_0001);
    add_local(8'd6, 8'h13, 32'h0000_0100);
    add_io(8'd7, 8'h21, 32'h1234_5678, 32'hFFFF_FFFF);
    send_table(SUM_FIX);

    // A zero-base I/O entry is overwritten by the next; once a nonzero base is
    // held, later I/O entries are ignored. The checksum is made to fail.
    start_table(32'hFFFF_FFFF);
    add_io(8'd12, 8'h03, 32'd0, 32'd5);
    add_entry(8'h55, 8'd2, 8'd0, 8'd0, 32'd0, 32'd0);
    add_io(8'd12, 8'h04, 32'hFEC0_1000, 32'd24);
    add_io(8'd12, 8'h05, 32'hAAAA_0000, 32'd48);
    add_local(8'd8, 8'h31, 32'h0000_0001);
    send_table(SUM_BREAK);

    // Entry length one stops the walk; well-formed entries after it are ignored.
    start_table($urandom);
    add_local(8'd8, 8'h41, 32'h0000_0001);
    add_entry(8'h20, 8'd1, 8'd0, 8'd0, 32'd0, 32'd0);
    add_local(8'd8, 8'h42, 32'h0000_0001);
    send_table(SUM_FIX);

    // Entry length zero on the first entry.
    start_table($urandom);
    add_entry(cfg_local_type, 8'd0, 8'd0, 8'd0, 32'd0, 32'd0);
    add_local(8'd8, 8'h43, 32'h0000_0001);
    send_table(SUM_FIX);

    // An entry cut off by the end of the table produces nothing.
    start_table($urandom);
    add_local(8'd8, 8'h51, 32'h0000_0001);
    add_local(8'd8, 8'h52, 32'h0000_0001);
    repeat (3) void'(table_bytes.pop_back());
    send_table(SUM_FIX);

    // The final byte completes an enabled entry: id record first, then the summary.
    start_table($urandom);
    add_local(8'd8, 8'h61, 32'h0000_0001);
    send_table(SUM_FIX);

    // Tables that end inside or right at the end of the header.
    table_bytes.delete();
    table_bytes.push_back(8'h00);
    send_table(SUM_KEEP);
    table_bytes.delete();
    table_bytes.push_back(8'hFF);
    send_table(SUM_KEEP);
    start_table(32'h0000_0001);
    send_table(SUM_FIX);
    start_table($urandom);
    void'(table_bytes.pop_back());
    send_table(SUM_KEEP);
  endtask

  // One table exercising the current configuration's type codes and mask.
  task automatic send_config_probe_table();
    start_table($urandom);
    add_local(8'd8, 8'h01, cfg_mask);
    add_local(8'd8, 8'h02, ~cfg_mask);
    add_local(8'd8, 8'h03, 32'hFFFF_FFFF);
    add_io(8'd12, 8'h04, 32'hFEC0_0000, 32'd0);
    add_entry(8'd0, 8'd8, 8'd0, 8'h05, 32'hFFFF_FFFF, 32'd0);
    add_entry(8'd255, 8'd8, 8'd0, 8'h06, 32'hFFFF_FFFF, 32'd0);
    add_entry(8'd1, 8'd12, 8'h07, 8'd0, 32'h1111_0000, 32'd0);
    send_table(SUM_FIX);
  endtask

  task automatic test_register_extremes();
    set_parser_config(8'd255, 8'd0, 32'hFFFF_FFFF);
    send_config_probe_table();
    set_parser_config(8'd0, 8'd255, 32'h8000_0000);
    send_config_probe_table();
    // Equal type codes: a matching entry is handled as a local entry only.
    set_parser_config(8'h5A, 8'h5A, 32'h0000_0100);
    send_config_probe_table();
    set_parser_config(8'd0, 8'd1, 32'd0);
    send_config_probe_table();
  endtask

  // More enabled entries than the MAX_LAPICS limit allows; the surplus produces nothing.
  task automatic test_lapic_saturation();
    int k;
    set_parser_config(ietp_pkg::LOCAL_TYPE_RST, ietp_pkg::IO_TYPE_RST, 32'h0000_00FF);
    start_table(ietp_pkg::DEFAULT_LOCAL_BASE);
    for (k = 0; k < ietp_pkg::MAX_LAPICS_DEF + 4; k++)
      add_local(8'd5, k[7:0], {24'd0, 8'($urandom_range(1, 255))});
    add_io(8'd12, 8'h09, 32'hFEC0_0000, 32'd0);
    send_table(SUM_FIX);
  endtask

  // The receiver holds off while a table dense in records keeps arriving, so
  // the result queue fills and the byte channel must stall.
  task automatic test_result_backpressure();
    int k;
    wait_for_idle();
    hold_requests++;
    start_table($urandom);
    for (k = 0; k < 16; k++) add_local(8'd5, 8'($urandom_range(255)), 32'h0000_00FF);
    send_table(SUM_FIX);
  endtask

  task automatic build_random_table();
    int         n_entries;
    int         k;
    int         pick;
    logic [7:0] len;
    table_bytes.delete();
    // Now and then pure noise, often ending before the entries begin.
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 60)) table_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    case ($urandom_range(2))
      0:       start_table(32'd0);
      1:       start_table(ietp_pkg::DEFAULT_LOCAL_BASE);
      default: start_table($urandom);
    endcase
    n_entries = $urandom_range(0, 6);
    for (k = 0; k < n_entries; k++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = ($urandom_range(3) == 0) ? 8'($urandom_range(2, 12)) : 8'd8;
        add_local(len, 8'($urandom_range(255)), random_flags());
      end else if (pick < 65) begin
        len = ($urandom_range(3) == 0) ? 8'($urandom_range(2, 16)) : 8'd12;
        add_io(len, 8'($urandom_range(255)), ($urandom_range(3) == 0) ? 32'd0 : $urandom,
               $urandom);
      end else if (pick < 85) begin
        add_entry(8'($urandom_range(255)), 8'($urandom_range(2, 24)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), $urandom, $urandom);
      end else if (pick < 92) begin
        add_entry(8'($urandom_range(255)), 8'($urandom_range(1)), 8'd0, 8'd0, 32'd0, 32'd0);
        repeat ($urandom_range(0, 8)) table_bytes.push_back(8'($urandom_range(255)));
      end else begin
        // Cut the final entry short; nothing may follow it.
        add_local(8'd8, 8'($urandom_range(255)), cfg_mask);
        repeat ($urandom_range(1, 7)) void'(table_bytes.pop_back());
        k = n_entries;
      end
    end
  endtask

  task automatic test_random_tables();
    int phase;
    int phase_start;
    int pick;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 37; recv_idle_pct = 56; end
        1:       begin send_idle_pct = 56; recv_idle_pct = 37; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      pick = $urandom_range(255);
      set_parser_config(($urandom_range(3) == 0) ? 8'd0 : 8'(pick),
                        ($urandom_range(7) == 0) ? 8'(pick) : 8'($urandom_range(255)),
                        ($urandom_range(3) == 0) ? 32'h0000_0001 : ($urandom & $urandom));
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RANDOM_BYTES_PER_PHASE) begin
        build_random_table();
        pick = $urandom_range(9);
        send_table((pick < 7) ? SUM_FIX : (pick < 9) ? SUM_KEEP : SUM_BREAK);
      end
    end
  endtask

  // Result checker and receiver: compares each accepted record with the oldest
  // prediction, then decides out_ready for the next cycle.
  always @(posedge clk) begin
    ietp_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_records.size() == 0) begin
        report_mismatch("record with nothing predicted", {31'd0, out_record_kind}, 32'd0);
      end else begin
        want = pending_records.pop_front();
        if (out_record_kind != want.record_kind)
          report_mismatch("record_kind", 32'(out_record_kind), 32'(want.record_kind));
        if (out_local_id != want.local_id)
          report_mismatch("local_id", 32'(out_local_id), 32'(want.local_id));
        if (out_sum_ok != want.sum_ok)
          report_mismatch("sum_ok", 32'(out_sum_ok), 32'(want.sum_ok));
        if (out_local_count != want.local_count)
          report_mismatch("local_count", 32'(out_local_count), 32'(want.local_count));
        if (out_local_base != want.local_base)
          report_mismatch("local_base", out_local_base, want.local_base);
        if (out_io_found != want.io_found)
          report_mismatch("io_found", 32'(out_io_found), 32'(want.io_found));
        if (out_io_base != want.io_base)
          report_mismatch("io_base", out_io_base, want.io_base);
        if (out_io_irq_base != want.io_irq_base)
          report_mismatch("io_irq_base", out_io_irq_base, want.io_irq_base);
        if (out_io_id != want.io_id)
          report_mismatch("io_id", 32'(out_io_id), 32'(want.io_id));
        if (out_malformed != want.malformed)
          report_mismatch("malformed", 32'(out_malformed), 32'(want.malformed));
        if (out_run_end != want.run_end)
          report_mismatch("run_end", 32'(out_run_end), 32'(want.run_end));
      end
      records_checked++;
    end

    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = RESULT_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any transfer on either channel or access on the register port counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_registers();
    test_entry_edge_cases();
    test_register_extremes();
    test_lapic_saturation();
    test_result_backpressure();
    test_random_tables();
    wait_for_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/ietp_pkg.sv
hdl/ietp_parser.sv
hdl/ietp_outq.sv
hdl/interrupt_table_entry_parser_unit.sv
bench/tb_top.sv
